>>> sv/radial_glow_pixel_generator_defines.svh
// assertion macros for the radial glow pixel generator checker
// no dependencies; included by the checker file
`ifndef RADIAL_GLOW_PIXEL_GENERATOR_DEFINES_SVH
`define RADIAL_GLOW_PIXEL_GENERATOR_DEFINES_SVH

// condition holds at every edge outside reset
`define RGPG_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rgpg check failed");

// same-cycle implication outside reset
`define RGPG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("rgpg check failed");

// next-cycle implication, also checked across reset
`define RGPG_ASSERT_AFTER(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rgpg check failed");

`endif

>>> sv/rgpg_pkg.sv
// shared types, constants and helpers for the radial glow pixel generator
// no dependencies; used by every module of the block
`default_nettype none

package rgpg_pkg;

   localparam int COORD_BITS    = 12;
   localparam int REG_BITS      = COORD_BITS + 1;
   localparam int SUM_BITS      = COORD_BITS + 2;
   localparam int OFS_BITS      = COORD_BITS + 3;
   localparam int SQ_BITS       = 2 * COORD_BITS + 4;
   localparam int SSUM_BITS     = 2 * COORD_BITS + 6;
   localparam int ROOT_INT_BITS = COORD_BITS + 3;
   localparam int DEN_BITS      = COORD_BITS + 6;

   localparam int NUM_SCALE = 5;
   localparam int DEN_SCALE = 19;

   localparam int OPA_BITS      = 9;
   localparam int OPA_FRAC_BITS = 8;
   localparam logic [OPA_BITS-1:0] OPA_FULL = 9'd256;

   localparam int CHAN_BITS  = 8;
   localparam int COLOR_BITS = 6;
   localparam logic [COLOR_BITS-1:0] GLOW_R = 6'h19;
   localparam logic [COLOR_BITS-1:0] GLOW_G = 6'h20;
   localparam logic [COLOR_BITS-1:0] GLOW_B = 6'h28;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [REG_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

   typedef enum logic [2:0] {
      REG_RECT_LEFT,
      REG_RECT_TOP,
      REG_RECT_RIGHT,
      REG_RECT_BOTTOM,
      REG_GLOW_OPACITY,
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT
   } reg_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic                   write_enable;
      logic [3*CHAN_BITS-1:0] pixel_word;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } side_type;

   // request accept edge to result accept edge
   function automatic int latency(input int frac_bits);
      return ROOT_INT_BITS + 2 * frac_bits + 10;
   endfunction

endpackage

`default_nettype wire

>>> sv/rgpg_sqrt.sv
// pipelined digit-by-digit square root, one root bit per stage
// depends on rgpg_pkg
`default_nettype none

module rgpg_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  rgpg_pkg::side_type                            up_side,
   input  logic [rgpg_pkg::SSUM_BITS-1:0]                radicand,
   output rgpg_pkg::side_type                            dn_side,
   output logic [rgpg_pkg::ROOT_INT_BITS+FRAC_BITS-1:0]  root
);

   localparam int ROOT_BITS = rgpg_pkg::ROOT_INT_BITS + FRAC_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int RAD_BITS  = rgpg_pkg::SSUM_BITS;
   localparam int STAGES    = ROOT_BITS;

   rgpg_pkg::side_type      side_ff [STAGES];
   logic [RAD_BITS-1:0]     rad_ff  [STAGES];
   logic [REM_BITS-1:0]     rem_ff  [STAGES];
   logic [ROOT_BITS-1:0]    root_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      rgpg_pkg::side_type   side_prev;
      logic [RAD_BITS-1:0]  rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS-1:0]  rem_shift;
      logic [REM_BITS-1:0]  trial;
      logic                 take;
      logic [REM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_in;
      logic [RAD_BITS-1:0]  rad_in;

      if (g == 0) begin : g_first
         assign side_prev = up_side;
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign side_prev = side_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
      end

      assign rem_shift = {rem_prev[REM_BITS-3:0], rad_prev[RAD_BITS-1 -: 2]};
      assign trial     = {root_prev, 2'b01};
      assign take      = rem_shift >= trial;
      assign rem_in    = take ? rem_shift - trial : rem_shift;
      assign root_in   = {root_prev[ROOT_BITS-2:0], take};
      assign rad_in    = rad_prev << 2;

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[g] <= '0;
         end else begin
            side_ff[g] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_in;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
      end
   end

   assign dn_side = side_ff[STAGES-1];
   assign root    = root_ff[STAGES-1];

endmodule

`default_nettype wire

>>> sv/rgpg_div.sv
// pipelined restoring divider: range check stage, then one quotient bit per stage
// depends on rgpg_pkg; clears the hit flag when the quotient reaches one
`default_nettype none

module rgpg_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rgpg_pkg::side_type                       up_side,
   input  logic [rgpg_pkg::DEN_BITS+FRAC_BITS-1:0]  numer,
   input  logic [rgpg_pkg::DEN_BITS-1:0]            denom,
   output rgpg_pkg::side_type                       dn_side,
   output logic [FRAC_BITS-1:0]                     quot
);

   localparam int NUM_BITS = rgpg_pkg::DEN_BITS + FRAC_BITS;
   localparam int STAGES   = FRAC_BITS + 1;

   rgpg_pkg::side_type   side_ff [STAGES];
   logic [NUM_BITS-1:0]  rem_ff  [STAGES];
   logic [FRAC_BITS-1:0] quot_ff [STAGES];

   logic [NUM_BITS-1:0]  limit;
   logic                 fits;
   rgpg_pkg::side_type   side_first_in;

   assign limit = {denom, {FRAC_BITS{1'b0}}};
   assign fits  = numer < limit;

   always_comb begin
      side_first_in     = up_side;
      side_first_in.hit = up_side.hit & fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else begin
         side_ff[0] <= side_first_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= numer;
      quot_ff[0] <= '0;
   end

   for (genvar g = 1; g < STAGES; g++) begin : g_step
      logic [NUM_BITS-1:0]  sub_val;
      logic                 take;
      logic [NUM_BITS-1:0]  rem_in;
      logic [FRAC_BITS-1:0] quot_in;

      assign sub_val = NUM_BITS'(denom) << (FRAC_BITS - g);
      assign take    = rem_ff[g-1] >= sub_val;
      assign rem_in  = take ? rem_ff[g-1] - sub_val : rem_ff[g-1];
      assign quot_in = {quot_ff[g-1][FRAC_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[g] <= '0;
         end else begin
            side_ff[g] <= side_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         quot_ff[g] <= quot_in;
      end
   end

   assign dn_side = side_ff[STAGES-1];
   assign quot    = quot_ff[STAGES-1];

endmodule

`default_nettype wire

>>> sv/radial_glow_pixel_generator.sv
// top level of the radial glow pixel generator; depends on rgpg_pkg, rgpg_sqrt, rgpg_div
// throughput: one request per cycle, busy only during reset and in the cycle after reset; results cannot stall
// depth is set by the square root (one root bit per stage) and the divider (one bit per stage)
// reset: synchronous, clears the pipeline valid bits and loads register reset values
`default_nettype none

module radial_glow_pixel_generator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rgpg_pkg::req_type                    req_payload,
   output logic                                 rsp_strobe,
   output rgpg_pkg::rsp_type                    rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rgpg_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [rgpg_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [rgpg_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   localparam int COORD_BITS  = rgpg_pkg::COORD_BITS;
   localparam int REG_BITS    = rgpg_pkg::REG_BITS;
   localparam int SUM_BITS    = rgpg_pkg::SUM_BITS;
   localparam int OFS_BITS    = rgpg_pkg::OFS_BITS;
   localparam int SQ_BITS     = rgpg_pkg::SQ_BITS;
   localparam int SSUM_BITS   = rgpg_pkg::SSUM_BITS;
   localparam int DEN_BITS    = rgpg_pkg::DEN_BITS;
   localparam int OPA_BITS    = rgpg_pkg::OPA_BITS;
   localparam int DATA_BITS   = rgpg_pkg::CSR_DATA_BITS;
   localparam int ADDR_BITS   = rgpg_pkg::CSR_ADDR_BITS;
   localparam int CHAN_BITS   = rgpg_pkg::CHAN_BITS;
   localparam int COLOR_BITS  = rgpg_pkg::COLOR_BITS;
   localparam int ROOT_BITS   = rgpg_pkg::ROOT_INT_BITS + FRAC_BITS;
   localparam int NUM_BITS    = DEN_BITS + FRAC_BITS;
   localparam int T_BITS      = FRAC_BITS + 1;
   localparam int TSQ_BITS    = 2 * T_BITS;
   localparam int K_BITS      = FRAC_BITS + 2;
   localparam int SMOOTH_BITS = T_BITS + K_BITS;
   localparam int ALPHA_BITS  = T_BITS + OPA_BITS;
   localparam int CPROD_BITS  = ALPHA_BITS + COLOR_BITS;

   localparam logic [T_BITS-1:0]     T_ONE      = T_BITS'(1) << FRAC_BITS;
   localparam logic [K_BITS-1:0]     K_THREE    = K_BITS'(3) << FRAC_BITS;
   localparam logic [CPROD_BITS-1:0] ROUND_HALF =
      CPROD_BITS'(1) << (FRAC_BITS + rgpg_pkg::OPA_FRAC_BITS - 1);

   function automatic logic [CHAN_BITS-1:0] scale_chan(
      input logic [COLOR_BITS-1:0] color,
      input logic [ALPHA_BITS-1:0] alpha
   );
      logic [CPROD_BITS-1:0] total;
      total = CPROD_BITS'(color) * CPROD_BITS'(alpha) + ROUND_HALF;
      return total[FRAC_BITS + rgpg_pkg::OPA_FRAC_BITS +: CHAN_BITS];
   endfunction

   // configuration registers
   logic [REG_BITS-1:0] rect_left_ff;
   logic [REG_BITS-1:0] rect_top_ff;
   logic [REG_BITS-1:0] rect_right_ff;
   logic [REG_BITS-1:0] rect_bottom_ff;
   logic [OPA_BITS-1:0] glow_opacity_ff;
   logic [REG_BITS-1:0] frame_width_ff;
   logic [REG_BITS-1:0] frame_height_ff;

   logic                    csr_write;
   rgpg_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = rgpg_pkg::reg_index_type'(paddr[ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff    <= '0;
         rect_top_ff     <= '0;
         rect_right_ff   <= '0;
         rect_bottom_ff  <= '0;
         glow_opacity_ff <= '0;
         frame_width_ff  <= rgpg_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= rgpg_pkg::FRAME_HEIGHT_RST;
      end else if (csr_write) begin
         case (csr_index)
            rgpg_pkg::REG_RECT_LEFT:    rect_left_ff    <= pwdata[REG_BITS-1:0];
            rgpg_pkg::REG_RECT_TOP:     rect_top_ff     <= pwdata[REG_BITS-1:0];
            rgpg_pkg::REG_RECT_RIGHT:   rect_right_ff   <= pwdata[REG_BITS-1:0];
            rgpg_pkg::REG_RECT_BOTTOM:  rect_bottom_ff  <= pwdata[REG_BITS-1:0];
            rgpg_pkg::REG_GLOW_OPACITY: glow_opacity_ff <= pwdata[OPA_BITS-1:0];
            rgpg_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[REG_BITS-1:0];
            rgpg_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (csr_index)
         rgpg_pkg::REG_RECT_LEFT:    prdata = DATA_BITS'(rect_left_ff);
         rgpg_pkg::REG_RECT_TOP:     prdata = DATA_BITS'(rect_top_ff);
         rgpg_pkg::REG_RECT_RIGHT:   prdata = DATA_BITS'(rect_right_ff);
         rgpg_pkg::REG_RECT_BOTTOM:  prdata = DATA_BITS'(rect_bottom_ff);
         rgpg_pkg::REG_GLOW_OPACITY: prdata = DATA_BITS'(glow_opacity_ff);
         rgpg_pkg::REG_FRAME_WIDTH:  prdata = DATA_BITS'(frame_width_ff);
         rgpg_pkg::REG_FRAME_HEIGHT: prdata = DATA_BITS'(frame_height_ff);
         default:                    prdata = '0;
      endcase
   end

   // values derived from the registers; keep them static while requests are in flight (not enforced here)
   logic signed [SUM_BITS-1:0] span_x;
   logic signed [SUM_BITS-1:0] span_y;
   logic signed [SUM_BITS-1:0] span_max;
   logic [REG_BITS-1:0]        span_mag;
   logic signed [SUM_BITS-1:0] center_x_in;
   logic signed [SUM_BITS-1:0] center_y_in;
   logic [DEN_BITS-1:0]        denom_in;
   logic [OPA_BITS-1:0]        opacity_in;
   logic                       enable_in;

   logic signed [SUM_BITS-1:0] center_x_ff;
   logic signed [SUM_BITS-1:0] center_y_ff;
   logic [DEN_BITS-1:0]        denom_ff;
   logic [OPA_BITS-1:0]        opacity_ff;
   logic                       enable_ff;

   always_comb begin
      span_x      = SUM_BITS'($signed(rect_right_ff)) - SUM_BITS'($signed(rect_left_ff));
      span_y      = SUM_BITS'($signed(rect_bottom_ff)) - SUM_BITS'($signed(rect_top_ff));
      span_max    = (span_x > span_y) ? span_x : span_y;
      span_mag    = span_max[REG_BITS-1:0];
      center_x_in = SUM_BITS'($signed(rect_left_ff)) + SUM_BITS'($signed(rect_right_ff));
      center_y_in = SUM_BITS'($signed(rect_top_ff)) + SUM_BITS'($signed(rect_bottom_ff));
      denom_in    = DEN_BITS'(span_mag) * DEN_BITS'(rgpg_pkg::DEN_SCALE);
      opacity_in  = (glow_opacity_ff > rgpg_pkg::OPA_FULL) ? rgpg_pkg::OPA_FULL
                                                             : glow_opacity_ff;
      enable_in   = (opacity_in != '0) && (span_max > SUM_BITS'(0));
   end

   always_ff @(posedge clock) begin
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
      denom_ff    <= denom_in;
      opacity_ff  <= opacity_in;
      enable_ff   <= enable_in;
   end

   // request side
   logic busy_ff;
   logic req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign req_accept = start & ~busy;

   // stage 1: capture
   logic                  s1_valid_ff;
   logic [COORD_BITS-1:0] px_ff;
   logic [COORD_BITS-1:0] py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= req_payload.pixel_x;
      py_ff <= req_payload.pixel_y;
   end

   // stage 2: half-pixel offsets and clipping
   rgpg_pkg::side_type         s2_side_in;
   rgpg_pkg::side_type         s2_side_ff;
   logic signed [OFS_BITS-1:0] dx_in;
   logic signed [OFS_BITS-1:0] dy_in;
   logic signed [OFS_BITS-1:0] dx_ff;
   logic signed [OFS_BITS-1:0] dy_ff;

   always_comb begin
      dx_in = OFS_BITS'($signed({1'b0, px_ff, 1'b1})) - OFS_BITS'(center_x_ff);
      dy_in = OFS_BITS'($signed({1'b0, py_ff, 1'b1})) - OFS_BITS'(center_y_ff);
      s2_side_in.valid = s1_valid_ff;
      s2_side_in.hit   = enable_ff && ({1'b0, px_ff} < frame_width_ff)
                                   && ({1'b0, py_ff} < frame_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
      end else begin
         s2_side_ff <= s2_side_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   // stage 3: squares
   rgpg_pkg::side_type           s3_side_ff;
   logic signed [2*OFS_BITS-1:0] prod_x;
   logic signed [2*OFS_BITS-1:0] prod_y;
   logic [SQ_BITS-1:0]           sqx_ff;
   logic [SQ_BITS-1:0]           sqy_ff;

   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff <= '0;
      end else begin
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff <= prod_x[SQ_BITS-1:0];
      sqy_ff <= prod_y[SQ_BITS-1:0];
   end

   // stage 4: squared distance
   rgpg_pkg::side_type   s4_side_ff;
   logic [SSUM_BITS-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff <= '0;
      end else begin
         s4_side_ff <= s3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= SSUM_BITS'(sqx_ff) + SSUM_BITS'(sqy_ff);
   end

   // square root
   rgpg_pkg::side_type   root_side;
   logic [ROOT_BITS-1:0] root;

   rgpg_sqrt #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .up_side  (s4_side_ff),
      .radicand (rad_ff),
      .dn_side  (root_side),
      .root     (root)
   );

   // numerator scale
   rgpg_pkg::side_type  numer_side_ff;
   logic [NUM_BITS-1:0] numer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         numer_side_ff <= '0;
      end else begin
         numer_side_ff <= root_side;
      end
   end

   always_ff @(posedge clock) begin
      numer_ff <= NUM_BITS'(root) * NUM_BITS'(rgpg_pkg::NUM_SCALE);
   end

   // normalized distance
   rgpg_pkg::side_type   dist_side;
   logic [FRAC_BITS-1:0] norm_dist;

   rgpg_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .up_side (numer_side_ff),
      .numer   (numer_ff),
      .denom   (denom_ff),
      .dn_side (dist_side),
      .quot    (norm_dist)
   );

   // smoothstep: t and t*t
   rgpg_pkg::side_type  p1_side_ff;
   logic [T_BITS-1:0]   t_in;
   logic [T_BITS-1:0]   t_ff;
   logic [TSQ_BITS-1:0] tsq_ff;

   assign t_in = T_ONE - T_BITS'(norm_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_side_ff <= '0;
      end else begin
         p1_side_ff <= dist_side;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      tsq_ff <= TSQ_BITS'(t_in) * TSQ_BITS'(t_in);
   end

   // smoothstep: t2 * (3 - 2t)
   rgpg_pkg::side_type     p2_side_ff;
   logic [T_BITS-1:0]      t2;
   logic [K_BITS-1:0]      k_val;
   logic [SMOOTH_BITS-1:0] smooth_ff;

   assign t2    = tsq_ff[FRAC_BITS +: T_BITS];
   assign k_val = K_THREE - {t_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_side_ff <= '0;
      end else begin
         p2_side_ff <= p1_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      smooth_ff <= SMOOTH_BITS'(t2) * SMOOTH_BITS'(k_val);
   end

   // weight times opacity
   rgpg_pkg::side_type    p3_side_ff;
   logic [T_BITS-1:0]     weight;
   logic [ALPHA_BITS-1:0] alpha_ff;

   assign weight = smooth_ff[FRAC_BITS +: T_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_side_ff <= '0;
      end else begin
         p3_side_ff <= p2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff <= ALPHA_BITS'(weight) * ALPHA_BITS'(opacity_ff);
   end

   // output register
   logic              rsp_strobe_ff;
   rgpg_pkg::rsp_type rsp_in;
   rgpg_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_in.write_enable = p3_side_ff.hit;
      if (p3_side_ff.hit) begin
         rsp_in.pixel_word = {scale_chan(rgpg_pkg::GLOW_R, alpha_ff),
                              scale_chan(rgpg_pkg::GLOW_G, alpha_ff),
                              scale_chan(rgpg_pkg::GLOW_B, alpha_ff)};
      end else begin
         rsp_in.pixel_word = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= p3_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> sv/rgpg_checker.sv
// port-level checker for the radial glow pixel generator, bound to the top level
// depends on rgpg_pkg and radial_glow_pixel_generator_defines.svh
`default_nettype none
`include "radial_glow_pixel_generator_defines.svh"

module rgpg_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rgpg_pkg::rsp_type rsp_payload,
   input logic              pready
);

   localparam int LATENCY = rgpg_pkg::latency(FRAC_BITS);

   logic req_accept;

   assign req_accept = start && !busy;

   `RGPG_ASSERT_ALWAYS(a_pready_high, clock, reset, pready)
   `RGPG_ASSERT_AFTER(a_reset_quiet, clock, reset, busy && !rsp_strobe)
   `RGPG_ASSERT_IMPLY(a_request_answered, clock, reset, req_accept, ##LATENCY rsp_strobe)
   `RGPG_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_strobe, $past(req_accept, LATENCY))
   `RGPG_ASSERT_IMPLY(a_dark_pixel, clock, reset, rsp_strobe && !rsp_payload.write_enable, (rsp_payload.pixel_word == '0))

endmodule

bind radial_glow_pixel_generator rgpg_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_rgpg_checker (.*);

`default_nettype wire

>>> tb/sv/radial_glow_pixel_generator_test.sv
// self-checking testbench for radial_glow_pixel_generator: pixel requests, apb register writes
// predicts each glow pixel in a scoreboard class; depends on rgpg_pkg and the block's rtl
`timescale 1ns / 1ps

module radial_glow_pixel_generator_test;
   import rgpg_pkg::*;

   localparam int FRAC         = 16;
   localparam int UNKNOWN_REG  = 7;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_REQUESTS  = 110;

   class glow_scoreboard;
      logic [12:0] left_edge, top_edge, right_edge, bottom_edge;
      logic [12:0] frame_w, frame_h;
      logic [8:0]  opacity;
      rsp_type     expected_pixels[$];
      int          errors;

      function new();
         left_edge = '0;
         top_edge = '0;
         right_edge = '0;
         bottom_edge = '0;
         opacity = '0;
         frame_w = 13'd640;
         frame_h = 13'd480;
         errors = 0;
      endfunction

      function void set_reg(int idx, logic [31:0] value);
         case (idx)
            REG_RECT_LEFT: begin
               left_edge = value[12:0];
            end
            REG_RECT_TOP: begin
               top_edge = value[12:0];
            end
            REG_RECT_RIGHT: begin
               right_edge = value[12:0];
            end
            REG_RECT_BOTTOM: begin
               bottom_edge = value[12:0];
            end
            REG_GLOW_OPACITY: begin
               opacity = value[8:0];
            end
            REG_FRAME_WIDTH: begin
               frame_w = value[12:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_h = value[12:0];
            end
            default: begin
            end
         endcase
      endfunction

      // floor(sqrt(n)), n below 2^62
      function longint unsigned root_floor(longint unsigned n);
         longint unsigned root, trial;
         root = 0;
         for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n)
               root = trial;
         end
         return root;
      endfunction

      function logic [7:0] shade(longint unsigned base, longint unsigned weight);
         longint unsigned scaled;
         scaled = (base * weight + (64'd1 << (FRAC + 7))) >> (FRAC + 8);
         return scaled[7:0];
      endfunction

      function rsp_type glow_pixel(req_type p);
         longint px, py, l, t, r, b, m, dx2, dy2;
         longint unsigned op, dist_sq, root, d, one, fall, fall_sq, smooth, weight;
         rsp_type pix;
         pix = '0;
         px = p.pixel_x;
         py = p.pixel_y;
         l = $signed(left_edge);
         t = $signed(top_edge);
         r = $signed(right_edge);
         b = $signed(bottom_edge);
         op = (opacity > 9'd256) ? 256 : opacity;
         m = ((r - l) > (b - t)) ? (r - l) : (b - t);
         if (op == 0 || m < 1)
            return pix;
         if (px >= frame_w || py >= frame_h)
            return pix;
         // offsets in half pixels from the rectangle centre
         dx2 = 2 * px + 1 - (l + r);
         dy2 = 2 * py + 1 - (t + b);
         dist_sq = dx2 * dx2 + dy2 * dy2;
         root = root_floor(dist_sq << (2 * FRAC));
         // radius in half pixels is 3.8 * m
         d = (5 * root) / (19 * m);
         one = 64'd1 << FRAC;
         if (d >= one)
            return pix;
         fall = one - d;
         fall_sq = (fall * fall) >> FRAC;
         smooth = (fall_sq * (3 * one - 2 * fall)) >> FRAC;
         weight = smooth * op;
         pix.write_enable = 1'b1;
         pix.pixel_word = {shade(64'h19, weight), shade(64'h20, weight), shade(64'h28, weight)};
         return pix;
      endfunction

      function void note_request(req_type p);
         expected_pixels.push_back(glow_pixel(p));
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel result with no request pending: %h", got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, actual %0d", want.write_enable, got.write_enable);
            errors++;
         end
         if (got.pixel_word !== want.pixel_word) begin
            $error("pixel_word: expected %h, actual %h", want.pixel_word, got.pixel_word);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   glow_scoreboard board;
   int cycle_count = 0;
   int cur_l, cur_t, cur_r, cur_b;

   radial_glow_pixel_generator dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (start && busy === 1'b0)
            board.note_request(req_payload);
         if (rsp_strobe === 1'b1)
            board.check_pixel(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("radial_glow_pixel_generator_test: errors");
         $finish;
      end
   end

   task automatic push_pixel(input int x, input int y);
      req_type p;
      p.pixel_x = x[COORD_BITS-1:0];
      p.pixel_y = y[COORD_BITS-1:0];
      start <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= (CSR_ADDR_BITS)'(idx << 2);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      board.set_reg(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_glow(input int l, input int t, input int r, input int b,
                           input int op, input int fw, input int fh);
      start <= 1'b0;
      wait_drained();
      csr_write(REG_RECT_LEFT, l);
      csr_write(REG_RECT_TOP, t);
      csr_write(REG_RECT_RIGHT, r);
      csr_write(REG_RECT_BOTTOM, b);
      csr_write(REG_GLOW_OPACITY, op);
      csr_write(REG_FRAME_WIDTH, fw);
      csr_write(REG_FRAME_HEIGHT, fh);
      cur_l = l;
      cur_t = t;
      cur_r = r;
      cur_b = b;
   endtask

   task automatic random_setting();
      int l, t, r, b, op, fw, fh;
      if ($urandom_range(0, 7) == 0) begin
         l = int'($urandom_range(0, 8191)) - 4096;
         t = int'($urandom_range(0, 8191)) - 4096;
         r = int'($urandom_range(0, 8191)) - 4096;
         b = int'($urandom_range(0, 8191)) - 4096;
      end else begin
         l = int'($urandom_range(0, 1200)) - 100;
         t = int'($urandom_range(0, 900)) - 100;
         r = l + int'($urandom_range(1, 300));
         b = t + int'($urandom_range(1, 300));
      end
      op = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(256, 4096);
      fh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(256, 4096);
      set_glow(l, t, r, b, op, fw, fh);
   endtask

   // coordinate around the glow centre, or anywhere when reach is negative
   function automatic int near_coord(int lo_edge, int hi_edge, int reach);
      int v;
      if (reach < 0)
         return $urandom_range(0, 4095);
      v = (lo_edge + hi_edge) / 2 + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v;
   endfunction

   initial begin
      int idle_pct, span, reach;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // unused register index, must be ignored
      csr_write(UNKNOWN_REG, 32'hFFFF_FFFF);

      // centre, edges of the glow, frame clipping, coordinate extremes
      set_glow(100, 80, 180, 140, 256, 640, 480);
      push_pixel(140, 110);
      push_pixel(139, 109);
      push_pixel(0, 0);
      push_pixel(200, 110);
      push_pixel(291, 110);
      push_pixel(292, 110);
      push_pixel(639, 479);
      push_pixel(640, 110);
      push_pixel(140, 480);
      push_pixel(4095, 4095);
      push_pixel(4095, 0);
      push_pixel(0, 4095);
      // zero opacity, opacity above full, minimal opacity
      set_glow(100, 80, 180, 140, 0, 640, 480);
      push_pixel(140, 110);
      set_glow(100, 80, 180, 140, 511, 640, 480);
      push_pixel(140, 110);
      push_pixel(200, 110);
      set_glow(100, 80, 180, 140, 1, 640, 480);
      push_pixel(140, 110);
      // inverted rectangle, empty rectangle, one pixel wide rectangle
      set_glow(180, 140, 100, 80, 256, 640, 480);
      push_pixel(140, 110);
      set_glow(50, 50, 50, 50, 256, 640, 480);
      push_pixel(50, 50);
      set_glow(10, 10, 11, 10, 256, 640, 480);
      push_pixel(10, 10);
      push_pixel(11, 10);
      // zero frame, then largest frame and rectangle
      set_glow(100, 80, 180, 140, 256, 0, 0);
      push_pixel(0, 0);
      set_glow(-4096, -4096, 4095, 4095, 256, 4096, 4096);
      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(2000, 3000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setting();
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 59;
            default: idle_pct = 22;
         endcase
         span = ((cur_r - cur_l) > (cur_b - cur_t)) ? (cur_r - cur_l) : (cur_b - cur_t);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            reach = (span < 1 || $urandom_range(0, 4) == 0) ? -1 : 2 * span + 4;
            push_pixel(near_coord(cur_l, cur_r, reach), near_coord(cur_t, cur_b, reach));
            if (i == PHASE_REQUESTS / 2) begin
               // hold off until the pipeline is empty
               start <= 1'b0;
               wait_drained();
            end else if (i < PHASE_REQUESTS - 1 && $urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("radial_glow_pixel_generator_test: clean");
      else
         $display("radial_glow_pixel_generator_test: errors");
      $finish;
   end

endmodule

>>> radial_glow_pixel_generator.f
+incdir+sv
sv/rgpg_pkg.sv
sv/rgpg_sqrt.sv
sv/rgpg_div.sv
sv/radial_glow_pixel_generator.sv
sv/rgpg_checker.sv
tb/sv/radial_glow_pixel_generator_test.sv
